[rtl/lru_cache_lookup_assert.svh]
`ifndef LRU_CACHE_LOOKUP_ASSERT_SVH
`define LRU_CACHE_LOOKUP_ASSERT_SVH

// Checks on the same cycle, sampled on clk, off while rst_n is low
`define LCL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks in the cycle after the antecedent
`define LCL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lcl_pkg.sv]
package lcl_pkg;

    localparam int DEPTH_DEF  = 8;
    localparam int KEY_W      = 32;
    localparam int CAP_W      = 4;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_PAD_W  = OUT_DATA_W - KEY_W - 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

    typedef struct packed {
        logic             hit;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } lcl_res_t;

endpackage

[rtl/lcl_engine.sv]
`include "lru_cache_lookup_assert.svh"

module lcl_engine #(
    parameter int DEPTH = lcl_pkg::DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lcl_pkg::KEY_W-1:0]  key,
    input  logic [lcl_pkg::CAP_W-1:0]  capacity,
    output logic                       idle,
    output logic                       res_valid,
    input  logic                       res_ready,
    output lcl_pkg::lcl_res_t          res
);

    localparam int KW    = lcl_pkg::KEY_W;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int MW    = KW + AW;
    localparam int CMP_W = (CW > lcl_pkg::CAP_W) ? CW : lcl_pkg::CAP_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_UPD  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            pvld_reg;
    logic [AW-1:0]   pidx_reg;
    logic [KW-1:0]   key_reg;
    logic            found_reg;
    logic [AW-1:0]   fidx_reg;
    logic [AW-1:0]   frank_reg;
    logic            vict_ok_reg;
    logic [AW-1:0]   vidx_reg;
    logic [AW-1:0]   vrank_reg;
    logic [KW-1:0]   vkey_reg;
    logic            free_ok_reg;
    logic [AW-1:0]   free_idx_reg;
    logic [DEPTH-1:0] valid_reg;
    logic [CW-1:0]   occ_reg;

    // key and recency rank per entry, {key, rank}
    logic [MW-1:0]   mem [DEPTH];
    logic [MW-1:0]   mem_rdata;
    logic [AW-1:0]   mem_raddr;
    logic            mem_we;
    logic [MW-1:0]   mem_wdata;

    logic            issue;
    logic            sweep_end;
    logic [KW-1:0]   rd_key;
    logic [AW-1:0]   rd_rank;
    logic            rd_valid;
    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] eff_cap;
    logic [CMP_W-1:0] occ_ext;
    logic            do_evict;
    logic [AW-1:0]   ins_idx;
    logic            fin_fire;

    assign issue     = ((state_reg == ST_SCAN) || (state_reg == ST_UPD))
                       && (cnt_reg != CW'(DEPTH));
    assign sweep_end = pvld_reg && (cnt_reg == CW'(DEPTH));
    assign mem_raddr = issue ? cnt_reg[AW-1:0] : '0;
    assign rd_key    = mem_rdata[MW-1:AW];
    assign rd_rank   = mem_rdata[AW-1:0];
    assign rd_valid  = valid_reg[pidx_reg];
    assign fin_fire  = (state_reg == ST_FIN) && res_ready;

    assign cap_ext = CMP_W'(capacity);
    assign occ_ext = CMP_W'(occ_reg);

    always_comb
    begin
        eff_cap = cap_ext;
        if (cap_ext == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(DEPTH))
        begin
            eff_cap = CMP_W'(DEPTH);
        end
    end

    assign do_evict = !found_reg && vict_ok_reg && (occ_ext >= eff_cap) && (occ_reg != '0);

    // new key goes to the lowest free slot, counting the victim's slot as free
    always_comb
    begin
        ins_idx = free_idx_reg;
        if (do_evict && (!free_ok_reg || (vidx_reg < free_idx_reg)))
        begin
            ins_idx = vidx_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sweep_end)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (sweep_end)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (sweep_end)
        begin
            cnt_next = '0;
        end
        else if (issue)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
    end

    // write-back pass: entry read last cycle is written now, next entry read meanwhile
    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = mem_rdata;
        if ((state_reg == ST_UPD) && pvld_reg)
        begin
            mem_we = 1'b1;
            if (found_reg)
            begin
                if (pidx_reg == fidx_reg)
                begin
                    mem_wdata = {rd_key, AW'(0)};
                end
                else if (rd_valid && (rd_rank < frank_reg))
                begin
                    mem_wdata = {rd_key, rd_rank + AW'(1)};
                end
            end
            else if (pidx_reg == ins_idx)
            begin
                mem_wdata = {key_reg, AW'(0)};
            end
            else if (rd_valid && !(do_evict && (pidx_reg == vidx_reg)))
            begin
                mem_wdata = {rd_key, rd_rank + AW'(1)};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[pidx_reg] <= mem_wdata;
        end
        mem_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            pvld_reg    <= 1'b0;
            found_reg   <= 1'b0;
            vict_ok_reg <= 1'b0;
            free_ok_reg <= 1'b0;
            valid_reg   <= '0;
            occ_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pvld_reg  <= issue;

            if ((state_reg == ST_IDLE) && start)
            begin
                found_reg   <= 1'b0;
                vict_ok_reg <= 1'b0;
                free_ok_reg <= 1'b0;
            end

            if ((state_reg == ST_SCAN) && pvld_reg)
            begin
                if (rd_valid && (rd_key == key_reg) && !found_reg)
                begin
                    found_reg <= 1'b1;
                end
                if (rd_valid && (!vict_ok_reg || (rd_rank > vrank_reg)))
                begin
                    vict_ok_reg <= 1'b1;
                end
                if (!rd_valid && !free_ok_reg)
                begin
                    free_ok_reg <= 1'b1;
                end
            end

            if ((state_reg == ST_UPD) && pvld_reg && !found_reg)
            begin
                if (pidx_reg == ins_idx)
                begin
                    valid_reg[pidx_reg] <= 1'b1;
                end
                else if (do_evict && (pidx_reg == vidx_reg))
                begin
                    valid_reg[pidx_reg] <= 1'b0;
                end
            end

            if (fin_fire && !found_reg && !do_evict)
            begin
                occ_reg <= occ_reg + CW'(1);
            end
        end
    end

    // payload side of the scan, no reset needed
    always_ff @(posedge clk)
    begin
        pidx_reg <= mem_raddr;
        if ((state_reg == ST_IDLE) && start)
        begin
            key_reg <= key;
        end
        if ((state_reg == ST_SCAN) && pvld_reg)
        begin
            if (rd_valid && (rd_key == key_reg) && !found_reg)
            begin
                fidx_reg  <= pidx_reg;
                frank_reg <= rd_rank;
            end
            if (rd_valid && (!vict_ok_reg || (rd_rank > vrank_reg)))
            begin
                vidx_reg  <= pidx_reg;
                vrank_reg <= rd_rank;
                vkey_reg  <= rd_key;
            end
            if (!rd_valid && !free_ok_reg)
            begin
                free_idx_reg <= pidx_reg;
            end
        end
    end

    assign idle            = (state_reg == ST_IDLE);
    assign res_valid       = (state_reg == ST_FIN);
    assign res.hit         = found_reg;
    assign res.evicted     = do_evict;
    assign res.evicted_key = do_evict ? vkey_reg : '0;

    `LCL_ASSERT_NOW(a_occ_matches_valid, state_reg == ST_IDLE,
        $countones(valid_reg) == occ_reg, "occupancy out of step with valid marks")
    `LCL_ASSERT_NOW(a_evict_only_when_full, res_valid && res.evicted,
        !res.hit && (occ_ext >= eff_cap), "eviction without a full store")
    `LCL_ASSERT_NOW(a_free_slot_on_fill, (state_reg == ST_UPD) && !found_reg && !do_evict,
        free_ok_reg, "miss without eviction found no free slot")
    `LCL_ASSERT_NEXT(a_occ_grows_on_fill, fin_fire && !found_reg && !do_evict,
        occ_reg == $past(occ_reg) + CW'(1), "occupancy did not grow on fill")

endmodule

[rtl/lru_cache_lookup.sv]
// Channel   Direction  tdata fields (low bit up)                  Width
// s_axis    in         key                                         32
// m_axis    out        hit, evicted, evicted_key, zero pad         40
// cfg       in         capacity (write enable, no read-back)        4
//
// An item takes one lookup sweep and one read-modify-write sweep over the
// key/rank memory, one entry a cycle each.
// Reset (rst_n, async, low) empties the store; capacity returns to 8.
// A stalled m_axis holds the finished transaction in the output register; the
// engine then waits in its final state before taking the next key.

module lru_cache_lookup #(
    parameter int DEPTH = lcl_pkg::DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lcl_pkg::KEY_W-1:0]       s_tdata,   // key
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lcl_pkg::OUT_DATA_W-1:0]  m_tdata,   // hit, evicted, evicted_key, pad
    input  logic                            cfg_we,
    input  logic [lcl_pkg::CAP_W-1:0]       cfg_wdata
);

    logic [lcl_pkg::CAP_W-1:0]      capacity_reg;
    logic                           m_tvalid_reg;
    logic [lcl_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    logic              eng_idle;
    logic              res_valid;
    logic              res_ready;
    lcl_pkg::lcl_res_t res;

    lcl_engine #(
        .DEPTH (DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_tvalid),
        .key       (s_tdata),
        .capacity  (capacity_reg),
        .idle      (eng_idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign s_tready  = eng_idle;
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= lcl_pkg::CAP_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            if (res_ready)
            begin
                m_tvalid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            m_tdata_reg <= {{lcl_pkg::OUT_PAD_W{1'b0}}, res.evicted_key, res.evicted, res.hit};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
